/* rtl/source_text_tokenizer_macros.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/stt_pkg.sv */
// Types, token codes and character helpers for the source text tokenizer.
package stt_pkg;

	// Token kinds as carried on the result channel.
	localparam logic [4:0] K_LPAREN  = 5'd0;
	localparam logic [4:0] K_RPAREN  = 5'd1;
	localparam logic [4:0] K_PLUS    = 5'd2;
	localparam logic [4:0] K_MINUS   = 5'd3;
	localparam logic [4:0] K_STAR    = 5'd4;
	localparam logic [4:0] K_SLASH   = 5'd5;
	localparam logic [4:0] K_ASSIGN  = 5'd6;
	localparam logic [4:0] K_COMMA   = 5'd7;
	localparam logic [4:0] K_EQ      = 5'd8;
	localparam logic [4:0] K_NE      = 5'd9;
	localparam logic [4:0] K_LT      = 5'd10;
	localparam logic [4:0] K_LE      = 5'd11;
	localparam logic [4:0] K_GT      = 5'd12;
	localparam logic [4:0] K_GE      = 5'd13;
	localparam logic [4:0] K_IF      = 5'd14;
	localparam logic [4:0] K_ELSE    = 5'd15;
	localparam logic [4:0] K_END     = 5'd16;
	localparam logic [4:0] K_PRINT   = 5'd17;
	localparam logic [4:0] K_IDENT   = 5'd18;
	localparam logic [4:0] K_NUMBER  = 5'd19;
	localparam logic [4:0] K_STRING  = 5'd20;
	localparam logic [4:0] K_EOF     = 5'd21;
	localparam logic [4:0] K_UNTERM  = 5'd22;
	localparam logic [4:0] K_BAD     = 5'd23;

	// Keyword slots in the candidate mask.
	localparam logic [1:0] KW_IF    = 2'd0;
	localparam logic [1:0] KW_ELSE  = 2'd1;
	localparam logic [1:0] KW_END   = 2'd2;
	localparam logic [1:0] KW_PRINT = 2'd3;

	// Identifier length counter saturates here.
	localparam logic [2:0] IDENT_LEN_MAX = 3'd6;

	// Largest number value.
	localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

	// Scanner modes.
	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_IDENT  = 6'b000010,
		MODE_NUMBER = 6'b000100,
		MODE_STRING = 6'b001000,
		MODE_SYMBOL = 6'b010000,
		MODE_ERROR  = 6'b100000
	} mode_t;

	// One result word.
	typedef struct packed {
		logic        is_token;
		logic [7:0]  text_byte;
		logic [4:0]  token_kind;
		logic [30:0] number_value;
		logic        last;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c >= 8'd9 && c <= 8'd13) || c == " ";
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Kind of a one-character symbol, or K_BAD.
	function automatic logic [4:0] single_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"/": k = K_SLASH;
			"=": k = K_ASSIGN;
			",": k = K_COMMA;
			"<": k = K_LT;
			">": k = K_GT;
			default: k = K_BAD;
		endcase
		return k;
	endfunction

	// Kind of a two-character operator, or K_BAD.
	function automatic logic [4:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
		logic [4:0] k;
		k = K_BAD;
		if (b == "=") begin
			unique case (a)
				"=": k = K_EQ;
				"!": k = K_NE;
				"<": k = K_LE;
				">": k = K_GE;
				default: k = K_BAD;
			endcase
		end
		return k;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] k);
		logic [2:0] l;
		unique case (k)
			KW_IF:    l = 3'd2;
			KW_ELSE:  l = 3'd4;
			KW_END:   l = 3'd3;
			KW_PRINT: l = 3'd5;
			default:  l = 3'd0;
		endcase
		return l;
	endfunction

	// Character of a keyword at a position; zero past its end.
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
		logic [7:0] ch;
		unique case ({k, pos})
			{KW_IF, 3'd0}:    ch = "i";
			{KW_IF, 3'd1}:    ch = "f";
			{KW_ELSE, 3'd0}:  ch = "e";
			{KW_ELSE, 3'd1}:  ch = "l";
			{KW_ELSE, 3'd2}:  ch = "s";
			{KW_ELSE, 3'd3}:  ch = "e";
			{KW_END, 3'd0}:   ch = "e";
			{KW_END, 3'd1}:   ch = "n";
			{KW_END, 3'd2}:   ch = "d";
			{KW_PRINT, 3'd0}: ch = "p";
			{KW_PRINT, 3'd1}: ch = "r";
			{KW_PRINT, 3'd2}: ch = "i";
			{KW_PRINT, 3'd3}: ch = "n";
			{KW_PRINT, 3'd4}: ch = "t";
			default:          ch = 8'd0;
		endcase
		return ch;
	endfunction

	// Does keyword k still match when byte c lands at position pos?
	function automatic logic kw_hit(input logic [1:0] k, input logic [2:0] pos,
			input logic [7:0] c);
		return (pos < kw_len(k)) && (kw_char(k, pos) == c);
	endfunction

	// Candidate mask after one more identifier byte.
	function automatic logic [3:0] cand_next(input logic [3:0] cand, input logic [2:0] len,
			input logic [7:0] c);
		logic [3:0] keep;
		keep[KW_IF]    = cand[KW_IF]    && kw_hit(KW_IF, len, c);
		keep[KW_ELSE]  = cand[KW_ELSE]  && kw_hit(KW_ELSE, len, c);
		keep[KW_END]   = cand[KW_END]   && kw_hit(KW_END, len, c);
		keep[KW_PRINT] = cand[KW_PRINT] && kw_hit(KW_PRINT, len, c);
		return keep;
	endfunction

	// Token kind of a finished identifier.
	function automatic logic [4:0] ident_kind(input logic [3:0] cand, input logic [2:0] len);
		logic [4:0] k;
		priority if (cand[KW_PRINT] && len == kw_len(KW_PRINT)) k = K_PRINT;
		else if (cand[KW_END] && len == kw_len(KW_END)) k = K_END;
		else if (cand[KW_ELSE] && len == kw_len(KW_ELSE)) k = K_ELSE;
		else if (cand[KW_IF] && len == kw_len(KW_IF)) k = K_IF;
		else k = K_IDENT;
		return k;
	endfunction

	function automatic result_t mk_text(input logic [7:0] c);
		result_t r;
		r = '0;
		r.text_byte = c;
		return r;
	endfunction

	function automatic result_t mk_tok(input logic [4:0] kind, input logic [30:0] value);
		result_t r;
		r = '0;
		r.is_token = 1'b1;
		r.token_kind = kind;
		r.number_value = value;
		return r;
	endfunction

endpackage

/* rtl/source_text_tokenizer.sv */
// Streaming source text tokenizer: source bytes in, text words and tokens out.
//
//  channel  | dir | tdata                          | tuser        | tlast
//  s_axis   | in  | char_in[7:0]                   | end_of_input | unused
//  m_axis   | out | text_byte, token_kind, number  | is_token     | last
//
// Each input word is scanned in the cycle it is accepted and its results (at most three
// are kept) land in a three-entry result register that drains one word per cycle while
// m_axis is ready. A word that yields at most one result is taken every cycle; a word that
// yields more holds the input side while the register drains down to its last word.
// Reset clears the scanner to idle and empties the result register.
// Backpressure on m_axis stalls input whenever the result register holds a word
// that does not leave in the same cycle.
`include "source_text_tokenizer_macros.svh"

module source_text_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
	input  logic        s_axis_tuser,  // [0] end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [7:0] text_byte, [12:8] token_kind,
	                                   // [43:13] number_value, [47:44] zero
	output logic        m_axis_tuser,  // [0] is_token
	output logic        m_axis_tlast   // last result of an input word
);
	import stt_pkg::*;

	// Scanner state.
	mode_t       mode_q, mode_d;
	logic [30:0] acc_q, acc_d;
	logic [3:0]  cand_q, cand_d;
	logic [2:0]  len_q, len_d;
	logic [7:0]  pend_q, pend_d;

	// Result register.
	result_t     res_q [3];
	logic [1:0]  cnt_q;

	// Scan outputs.
	result_t     res_d [4];
	result_t     ld [3];
	logic [2:0]  n_push;
	logic [1:0]  cnt_new;
	logic        do_idle;
	logic [7:0]  c;
	logic        eoi;
	logic [34:0] acc_mul;
	logic [4:0]  kind_p;
	logic [4:0]  kind_pair;
	logic        in_acc;
	logic        out_acc;

	assign c = s_axis_tdata;
	assign eoi = s_axis_tuser;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Accumulator times ten plus the digit.
	assign acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, c[3:0]};
	assign kind_p = single_kind(pend_q);
	assign kind_pair = pair_kind(pend_q, c);

	// Scan one word: next state and the list of results it causes.
	always_comb begin
		mode_d = mode_q;
		acc_d = acc_q;
		cand_d = cand_q;
		len_d = len_q;
		pend_d = pend_q;
		res_d = '{default: '0};
		n_push = 3'd0;
		do_idle = 1'b0;
		unique case (mode_q)
			MODE_IDLE: begin
				if (eoi) begin
					res_d[n_push[1:0]] = mk_tok(K_EOF, '0);
					n_push = n_push + 3'd1;
				end else begin
					do_idle = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (!eoi && (is_letter(c) || is_digit(c))) begin
					cand_d = cand_next(cand_q, len_q, c);
					len_d = (len_q < IDENT_LEN_MAX) ? len_q + 3'd1 : len_q;
					res_d[n_push[1:0]] = mk_text(c);
					n_push = n_push + 3'd1;
				end else begin
					res_d[n_push[1:0]] = mk_tok(ident_kind(cand_q, len_q), '0);
					n_push = n_push + 3'd1;
					cand_d = '0;
					len_d = '0;
					mode_d = MODE_IDLE;
					if (eoi) begin
						res_d[n_push[1:0]] = mk_tok(K_EOF, '0);
						n_push = n_push + 3'd1;
					end else begin
						do_idle = 1'b1;
					end
				end
			end
			MODE_NUMBER: begin
				if (!eoi && is_digit(c)) begin
					acc_d = (acc_mul > {4'd0, NUM_MAX}) ? NUM_MAX : acc_mul[30:0];
				end else begin
					res_d[n_push[1:0]] = mk_tok(K_NUMBER, acc_q);
					n_push = n_push + 3'd1;
					acc_d = '0;
					mode_d = MODE_IDLE;
					if (eoi) begin
						res_d[n_push[1:0]] = mk_tok(K_EOF, '0);
						n_push = n_push + 3'd1;
					end else begin
						do_idle = 1'b1;
					end
				end
			end
			MODE_STRING: begin
				if (eoi || c == 8'h0A) begin
					res_d[n_push[1:0]] = mk_tok(K_UNTERM, '0);
					n_push = n_push + 3'd1;
					mode_d = MODE_ERROR;
				end else if (c == "\"") begin
					res_d[n_push[1:0]] = mk_tok(K_STRING, '0);
					n_push = n_push + 3'd1;
					mode_d = MODE_IDLE;
				end else begin
					res_d[n_push[1:0]] = mk_text(c);
					n_push = n_push + 3'd1;
				end
			end
			MODE_SYMBOL: begin
				pend_d = '0;
				res_d[n_push[1:0]] = mk_text(pend_q);
				n_push = n_push + 3'd1;
				if (!eoi && kind_pair != K_BAD) begin
					// Two-character operator.
					res_d[n_push[1:0]] = mk_text(c);
					n_push = n_push + 3'd1;
					res_d[n_push[1:0]] = mk_tok(kind_pair, '0);
					n_push = n_push + 3'd1;
					mode_d = MODE_IDLE;
				end else begin
					// The held byte stands alone; a lone bang is an error.
					res_d[n_push[1:0]] = mk_tok(kind_p, '0);
					n_push = n_push + 3'd1;
					if (kind_p == K_BAD) begin
						mode_d = MODE_ERROR;
					end else begin
						mode_d = MODE_IDLE;
						if (eoi) begin
							res_d[n_push[1:0]] = mk_tok(K_EOF, '0);
							n_push = n_push + 3'd1;
						end else begin
							do_idle = 1'b1;
						end
					end
				end
			end
			MODE_ERROR: begin
				mode_d = MODE_ERROR;
			end
			default: begin
				mode_d = MODE_ERROR;
			end
		endcase

		// The byte starts a new token, or is skipped as white space.
		if (do_idle) begin
			priority if (is_space(c)) begin
				mode_d = MODE_IDLE;
			end else if (is_letter(c)) begin
				mode_d = MODE_IDENT;
				cand_d = cand_next(4'hF, 3'd0, c);
				len_d = 3'd1;
				res_d[n_push[1:0]] = mk_text(c);
				n_push = n_push + 3'd1;
			end else if (is_digit(c)) begin
				mode_d = MODE_NUMBER;
				acc_d = {27'd0, c[3:0]};
			end else if (c == "\"") begin
				mode_d = MODE_STRING;
			end else if (c == "<" || c == ">" || c == "=" || c == "!") begin
				mode_d = MODE_SYMBOL;
				pend_d = c;
			end else begin
				res_d[n_push[1:0]] = mk_text(c);
				n_push = n_push + 3'd1;
				res_d[n_push[1:0]] = mk_tok(single_kind(c), '0);
				n_push = n_push + 3'd1;
				mode_d = (single_kind(c) == K_BAD) ? MODE_ERROR : MODE_IDLE;
			end
		end
	end

	// At most three results are kept; mark the final one.
	always_comb begin
		cnt_new = (n_push > 3'd3) ? 2'd3 : n_push[1:0];
		ld[0] = res_d[0];
		ld[1] = res_d[1];
		ld[2] = res_d[2];
		ld[0].last = (cnt_new == 2'd1);
		ld[1].last = (cnt_new == 2'd2);
		ld[2].last = (cnt_new == 2'd3);
	end

	// Input is taken when the result register is empty or drains its last word now.
	assign s_axis_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);

	// Scanner state and result count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q <= '0;
			cand_q <= '0;
			len_q <= '0;
			pend_q <= '0;
			cnt_q <= '0;
		end else begin
			if (in_acc) begin
				mode_q <= mode_d;
				acc_q <= acc_d;
				cand_q <= cand_d;
				len_q <= len_d;
				pend_q <= pend_d;
				cnt_q <= cnt_new;
			end else if (out_acc) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Result words: load on accept, shift down as each one leaves.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q[0] <= ld[0];
			res_q[1] <= ld[1];
			res_q[2] <= ld[2];
		end else if (out_acc) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	// Output word.
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata = {4'd0, res_q[0].number_value, res_q[0].token_kind,
		res_q[0].text_byte};
	assign m_axis_tuser = res_q[0].is_token;
	assign m_axis_tlast = res_q[0].last;

	// The last flag rides only on the final buffered word.
	`STT_ASSERT_SAME(a_last_final, clk, arst_n, m_axis_tvalid && m_axis_tlast, cnt_q == 2'd1, "last flag on a word that is not the final one")
	// Error mode is left only through reset.
	`STT_ASSERT_NEXT(a_error_sticky, clk, arst_n, mode_q == MODE_ERROR, mode_q == MODE_ERROR, "scanner left error mode")
	// A word taken in error mode produces nothing.
	`STT_ASSERT_NEXT(a_error_silent, clk, arst_n, in_acc && mode_q == MODE_ERROR, cnt_q == 2'd0, "result produced in error mode")

endmodule
